### src/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation builds get concurrent
// assertions; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while the active-low reset is released.
`define CCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define CCC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define CCC_ASSERT(label, clk, rst_n, prop)
`define CCC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### src/ccc_pkg.sv
`default_nettype none

package ccc_pkg;

    // Default width of the stored player times.
    localparam int TIME_BITS_DEF = 24;

    // Field widths of the request and result items.
    localparam int MODE_W  = 3;
    localparam int REM_W   = 24;
    localparam int SHOWN_W = 22;
    localparam int INC_W   = 14;
    localparam int HOLD_W  = 16;
    localparam int BEEP_W  = 2;
    localparam int MIN_W   = 4;
    localparam int TENS_W  = 3;
    localparam int ISEC_W  = 4;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 80;

    localparam logic [HOLD_W-1:0] HOLD_RESET_DEF = 16'd3000;

    // Knob limits.
    localparam logic [MIN_W-1:0]  MIN_IDX_MAX = 4'd9;
    localparam logic [TENS_W-1:0] TENS_MAX    = 3'd5;
    localparam logic [ISEC_W-1:0] ISEC_MAX    = 4'd10;

    // Modes.
    localparam logic [MODE_W-1:0] MODE_SET_T1   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET_INC1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_T2   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_INC2 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PLAY     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FINISHED = 3'd6;

    // Beep codes.
    localparam logic [BEEP_W-1:0] BEEP_NONE    = 2'd0;
    localparam logic [BEEP_W-1:0] BEEP_CONFIRM = 2'd1;
    localparam logic [BEEP_W-1:0] BEEP_TIMEOUT = 2'd2;

    // Base time of each minutes knob position, in milliseconds.
    function automatic logic [SHOWN_W-1:0] minute_ms(input logic [MIN_W-1:0] idx);
        logic [SHOWN_W-1:0] ms;
        ms = '0;
        case (idx)
            4'd0:    ms = 22'd0;
            4'd1:    ms = 22'd60000;
            4'd2:    ms = 22'd120000;
            4'd3:    ms = 22'd180000;
            4'd4:    ms = 22'd300000;
            4'd5:    ms = 22'd600000;
            4'd6:    ms = 22'd900000;
            4'd7:    ms = 22'd1200000;
            4'd8:    ms = 22'd1800000;
            default: ms = 22'd3600000;
        endcase
        return ms;
    endfunction

endpackage

`default_nettype wire

### src/chess_clock_controller.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata  : one millisecond tick request
// m_        out        m_tvalid / m_tready   m_tdata  : clock status after the tick
// cfg_      in         cfg_valid / cfg_ready cfg_data : hold_reset_ms
//
// A tick request accepted at one edge sits in the input register while the mode update
// runs; its result enters the output register once the output is not stalled.
// A new request can be accepted in every cycle while the output does not stall; the
// game-state update between the two registers is combinational and allows that rate.
// A stalled result holds the output register and, once the input register is
// also full, s_tready drops. cfg_ready is always high.
// aresetn is synchronous and active low; it clears the game state and loads
// hold_reset_ms with 3000.
`default_nettype none

`include "assert_macros.svh"

module chess_clock_controller #(
    parameter int TIME_BITS = ccc_pkg::TIME_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [0] btn_one_level, [1] btn_two_level, [2] btn_ctrl_level,
    // [6:3] minutes_index, [9:7] tens_seconds, [13:10] increment_seconds
    input  wire logic [ccc_pkg::S_DATA_W-1:0]  s_tdata,

    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] mode_now, [3] side_to_move, [27:4] remaining_one,
    // [51:28] remaining_two, [73:52] shown_setting, [74] is_paused,
    // [76:75] beep_code
    output      logic [ccc_pkg::M_DATA_W-1:0]  m_tdata,

    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [ccc_pkg::HOLD_W-1:0]    cfg_data
);

    localparam int IN_W = 3 + ccc_pkg::MIN_W + ccc_pkg::TENS_W + ccc_pkg::ISEC_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Pipeline control.
    logic                in_valid_reg;
    logic [IN_W-1:0]     in_data_reg;
    logic                out_valid_reg;
    logic [ccc_pkg::M_DATA_W-1:0] out_data_reg;
    logic                out_ok;
    logic                step;

    // Game state.
    logic [ccc_pkg::HOLD_W-1:0]  hold_reset_ms_reg;
    logic [ccc_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic                        turn_reg, turn_next;
    logic [TIME_BITS-1:0]        time_one_reg, time_one_next;
    logic [TIME_BITS-1:0]        time_two_reg, time_two_next;
    logic [ccc_pkg::INC_W-1:0]   inc_one_reg, inc_one_next;
    logic [ccc_pkg::INC_W-1:0]   inc_two_reg, inc_two_next;
    logic                        pause_reg, pause_next;
    logic [ccc_pkg::HOLD_W-1:0]  hold_count_reg, hold_count_next;
    logic [2:0]                  prev_levels_reg;

    // Tick decode.
    logic                        lv1, lv2, lvc;
    logic [ccc_pkg::MIN_W-1:0]   mi_raw, mi;
    logic [ccc_pkg::TENS_W-1:0]  ts_raw, ts;
    logic [ccc_pkg::ISEC_W-1:0]  is_raw, is_sat;
    logic [ccc_pkg::SHOWN_W-1:0] set_time_ms;
    logic [ccc_pkg::INC_W-1:0]   set_inc_ms;
    logic                        cleared;
    logic [2:0]                  prev_eff;
    logic                        p1, p2, pc;
    logic [ccc_pkg::SHOWN_W-1:0] shown;
    logic [ccc_pkg::BEEP_W-1:0]  beep;
    logic [TIME_BITS:0]          sum_one, sum_two;
    logic [TIME_BITS-1:0]        dec_one, dec_two;

    assign out_ok    = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ok;
    assign s_tready  = !in_valid_reg || out_ok;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign lv1    = in_data_reg[0];
    assign lv2    = in_data_reg[1];
    assign lvc    = in_data_reg[2];
    assign mi_raw = in_data_reg[6:3];
    assign ts_raw = in_data_reg[9:7];
    assign is_raw = in_data_reg[13:10];

    assign mi     = (mi_raw > ccc_pkg::MIN_IDX_MAX) ? ccc_pkg::MIN_IDX_MAX : mi_raw;
    assign ts     = (ts_raw > ccc_pkg::TENS_MAX) ? ccc_pkg::TENS_MAX : ts_raw;
    assign is_sat = (is_raw > ccc_pkg::ISEC_MAX) ? ccc_pkg::ISEC_MAX : is_raw;

    assign set_time_ms = ccc_pkg::minute_ms(mi)
                       + ccc_pkg::SHOWN_W'(ts * 16'd10000);
    assign set_inc_ms  = ccc_pkg::INC_W'(is_sat * 14'd1000);

    always_comb begin
        mode_next       = mode_reg;
        turn_next       = turn_reg;
        time_one_next   = time_one_reg;
        time_two_next   = time_two_reg;
        inc_one_next    = inc_one_reg;
        inc_two_next    = inc_two_reg;
        pause_next      = pause_reg;
        hold_count_next = hold_count_reg;
        cleared         = 1'b0;
        shown           = '0;
        beep            = ccc_pkg::BEEP_NONE;
        sum_one         = '0;
        sum_two         = '0;
        dec_one         = time_one_reg - TIME_BITS'(1);
        dec_two         = time_two_reg - TIME_BITS'(1);

        // A long CTRL hold wipes the game before the tick is handled.
        if (lvc) begin
            if (!prev_levels_reg[2]) begin
                hold_count_next = '0;
            end else if (hold_count_reg != {ccc_pkg::HOLD_W{1'b1}}) begin
                hold_count_next = hold_count_reg + 1'b1;
            end
            if (hold_count_next >= hold_reset_ms_reg) begin
                cleared         = 1'b1;
                hold_count_next = '0;
                mode_next       = ccc_pkg::MODE_SET_T1;
                turn_next       = 1'b0;
                time_one_next   = '0;
                time_two_next   = '0;
                inc_one_next    = '0;
                inc_two_next    = '0;
                pause_next      = 1'b0;
            end
        end

        prev_eff = cleared ? 3'b000 : prev_levels_reg;
        p1 = prev_eff[0] && !lv1;
        p2 = prev_eff[1] && !lv2;
        pc = prev_eff[2] && !lvc;

        unique case (mode_next) inside
            ccc_pkg::MODE_SET_T1, ccc_pkg::MODE_SET_T2: begin
                shown = set_time_ms;
                if (set_time_ms != '0 && pc) begin
                    if (mode_next == ccc_pkg::MODE_SET_T1) begin
                        time_one_next = TIME_BITS'(set_time_ms);
                    end else begin
                        time_two_next = TIME_BITS'(set_time_ms);
                    end
                    beep      = ccc_pkg::BEEP_CONFIRM;
                    mode_next = mode_next + 1'b1;
                end
            end
            ccc_pkg::MODE_SET_INC1, ccc_pkg::MODE_SET_INC2: begin
                shown = ccc_pkg::SHOWN_W'(set_inc_ms);
                if (pc) begin
                    if (mode_next == ccc_pkg::MODE_SET_INC1) begin
                        inc_one_next = set_inc_ms;
                    end else begin
                        inc_two_next = set_inc_ms;
                    end
                    beep      = ccc_pkg::BEEP_CONFIRM;
                    mode_next = mode_next + 1'b1;
                end
            end
            ccc_pkg::MODE_START: begin
                mode_next = ccc_pkg::MODE_PLAY;
            end
            ccc_pkg::MODE_PLAY: begin
                if (!pause_reg) begin
                    if (time_one_reg == '0 || time_two_reg == '0) begin
                        mode_next = ccc_pkg::MODE_FINISHED;
                        beep      = ccc_pkg::BEEP_TIMEOUT;
                    end else if (!turn_reg) begin
                        // The pass adds the increment on top of the decremented time.
                        sum_one = {1'b0, dec_one} + (TIME_BITS + 1)'(inc_one_reg);
                        if (p1) begin
                            turn_next     = 1'b1;
                            time_one_next = sum_one[TIME_BITS] ? TIME_MAX
                                                               : sum_one[TIME_BITS-1:0];
                            beep          = ccc_pkg::BEEP_CONFIRM;
                        end else begin
                            time_one_next = dec_one;
                        end
                    end else begin
                        sum_two = {1'b0, dec_two} + (TIME_BITS + 1)'(inc_two_reg);
                        if (p2) begin
                            turn_next     = 1'b0;
                            time_two_next = sum_two[TIME_BITS] ? TIME_MAX
                                                               : sum_two[TIME_BITS-1:0];
                            beep          = ccc_pkg::BEEP_CONFIRM;
                        end else begin
                            time_two_next = dec_two;
                        end
                    end
                end
                if (pc) begin
                    pause_next = !pause_reg;
                    if (beep == ccc_pkg::BEEP_NONE) begin
                        beep = ccc_pkg::BEEP_CONFIRM;
                    end
                end
            end
            ccc_pkg::MODE_FINISHED: begin
                if (pc) begin
                    hold_count_next = '0;
                    mode_next       = ccc_pkg::MODE_SET_T1;
                    turn_next       = 1'b0;
                    time_one_next   = '0;
                    time_two_next   = '0;
                    inc_one_next    = '0;
                    inc_two_next    = '0;
                    pause_next      = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            hold_reset_ms_reg <= ccc_pkg::HOLD_RESET_DEF;
            mode_reg          <= ccc_pkg::MODE_SET_T1;
            turn_reg          <= 1'b0;
            time_one_reg      <= '0;
            time_two_reg      <= '0;
            inc_one_reg       <= '0;
            inc_two_reg       <= '0;
            pause_reg         <= 1'b0;
            hold_count_reg    <= '0;
            prev_levels_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hold_reset_ms_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ok) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step) begin
                mode_reg        <= mode_next;
                turn_reg        <= turn_next;
                time_one_reg    <= time_one_next;
                time_two_reg    <= time_two_next;
                inc_one_reg     <= inc_one_next;
                inc_two_reg     <= inc_two_next;
                pause_reg       <= pause_next;
                hold_count_reg  <= hold_count_next;
                prev_levels_reg <= {lvc, lv2, lv1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
        if (step) begin
            out_data_reg <= {3'b000, beep, pause_next, shown,
                             ccc_pkg::REM_W'(time_two_next),
                             ccc_pkg::REM_W'(time_one_next),
                             turn_next, mode_next};
        end
    end

    // The start mode always gives way to play, unless a long hold wipes the game.
    `CCC_ASSERT(a_start_leaves, aclk, aresetn,
        (step && mode_reg == ccc_pkg::MODE_START) |=>
        (mode_reg == ccc_pkg::MODE_PLAY || mode_reg == ccc_pkg::MODE_SET_T1))

    // Player one has no time until it is set.
    `CCC_ASSERT(a_t1_unset, aclk, aresetn,
        (mode_reg == ccc_pkg::MODE_SET_T1) |-> (time_one_reg == '0 && inc_one_reg == '0))

    // Player two settings stay clear until their own setup modes.
    `CCC_ASSERT(a_p2_unset, aclk, aresetn,
        (mode_reg == ccc_pkg::MODE_SET_T1 || mode_reg == ccc_pkg::MODE_SET_INC1 ||
         mode_reg == ccc_pkg::MODE_SET_T2) |-> (time_two_reg == '0 && inc_two_reg == '0))

    // Pause only exists in play or in the finished state it can carry into.
    `CCC_ASSERT(a_pause_mode, aclk, aresetn,
        pause_reg |-> (mode_reg == ccc_pkg::MODE_PLAY || mode_reg == ccc_pkg::MODE_FINISHED))

    // A result leaves the block only for a request that went through the input stage.
    `CCC_ASSERT(a_out_source, aclk, aresetn,
        $rose(out_valid_reg) |-> $past(in_valid_reg))

endmodule

`default_nettype wire
